// ===== rtl/hth_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hth_pkg: shared types and constants of the terrain height lookup
// Field widths, config register codes, stage types and the shared
// one-bit restoring division step.
// ----------------------------------------------------------------------------
package hth_pkg;

	localparam int MAX_VERTICES = 16384;
	localparam int ADDR_W       = $clog2(MAX_VERTICES);

	localparam int H_W    = 24;              // Q16.8 height
	localparam int POS_W  = 23;              // Q15.8 position
	localparam int IDX_W  = 14;              // vertex index field
	localparam int CFG_W  = 8;               // config register width
	localparam int FRAC_W = 8;               // fraction bits
	localparam int CELL_W = POS_W - FRAC_W;  // integer part of a position
	localparam int OFS_W  = CFG_W + FRAC_W;  // in-cell offset, 0..L-1
	localparam int FAR_W  = 2 * CFG_W + 1;   // row * cols + col + cols + 1

	localparam int IN_BITS   = IDX_W + H_W + 2 * POS_W;
	localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

	// interpolation arithmetic
	localparam int PROD_W = (H_W + 1) + (OFS_W + 1);
	localparam int NUM_W  = PROD_W + 1;
	localparam int DIV_W  = NUM_W - FRAC_W - 1;
	localparam int SUM_W  = DIV_W + 2;
	localparam int IP_STG = DIV_W + 4;       // s1, s2, s3, divide, output

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	localparam logic [1:0] CFG_COLS    = 2'd0;
	localparam logic [1:0] CFG_ROWS    = 2'd1;
	localparam logic [1:0] CFG_SPACING = 2'd2;

	typedef enum logic [1:0] {
		PH_BASE,
		PH_SIDE_A,
		PH_SIDE_B
	} seq_phase_t;

	typedef struct packed {
		logic [CFG_W-1:0] cols;
		logic [CFG_W-1:0] rows;
		logic [CFG_W-1:0] spacing;   // never zero
	} cfg_t;

	typedef struct packed {
		logic                    req;
		logic [IDX_W-1:0]        idx;
		logic signed [H_W-1:0]   hgt;
		logic [POS_W-1:0]        px;
		logic [POS_W-1:0]        pz;
	} req_item_t;

	typedef struct packed {
		logic                    req;
		logic [IDX_W-1:0]        idx;
		logic signed [H_W-1:0]   hgt;
		logic [FRAC_W-1:0]       xlo;
		logic [FRAC_W-1:0]       zlo;
		logic [CELL_W-1:0]       xq;   // dividend shifting out, quotient in
		logic [CELL_W-1:0]       zq;
		logic [CFG_W-1:0]        xr;
		logic [CFG_W-1:0]        zr;
	} cell_stage_t;

	typedef struct packed {
		logic                    req;
		logic [IDX_W-1:0]        idx;
		logic signed [H_W-1:0]   hgt;
		logic [CELL_W-1:0]       col;
		logic [CELL_W-1:0]       row;
		logic [OFS_W-1:0]        fx;
		logic [OFS_W-1:0]        fz;
	} cell_item_t;

	typedef struct packed {
		logic                    req;
		logic [IDX_W-1:0]        idx;
		logic signed [H_W-1:0]   hgt;
		logic                    off;
		logic [ADDR_W-1:0]       a_base;
		logic [ADDR_W-1:0]       a_a;
		logic [ADDR_W-1:0]       a_b;
		logic [OFS_W-1:0]        u;
		logic [OFS_W-1:0]        v;
	} prep_t;

	typedef struct packed {
		logic                    off;
		logic signed [H_W-1:0]   base;
		logic signed [H_W-1:0]   ha;
		logic signed [H_W-1:0]   hb;
		logic [OFS_W-1:0]        u;
		logic [OFS_W-1:0]        v;
	} interp_item_t;

	typedef struct packed {
		logic                    off;
		logic signed [H_W-1:0]   base;
		logic                    neg;
		logic [DIV_W-1:0]        dq;
		logic [CFG_W-1:0]        rem;
	} div_stage_t;

	// one restoring step: returns {quotient bit, new remainder}
	function automatic logic [CFG_W:0] div_step(input logic [CFG_W-1:0] rem,
		input logic nb, input logic [CFG_W-1:0] dsr);
		logic [CFG_W:0] w;
		logic [CFG_W:0] diff;
		w    = {rem, nb};
		diff = w - {1'b0, dsr};
		if (w >= {1'b0, dsr}) begin
			return {1'b1, diff[CFG_W-1:0]};
		end
		return {1'b0, w[CFG_W-1:0]};
	endfunction

endpackage
`default_nettype wire

// ===== rtl/hth_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hth_ram: generic single-port RAM
// One read or write per cycle, read data registered.
// ----------------------------------------------------------------------------
module hth_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/hth_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hth_cell: cell locator
// Pipelined restoring dividers split x and z into cell index and in-cell
// offset, one quotient bit per stage. Loads ride along to keep order.
// ----------------------------------------------------------------------------
module hth_cell import hth_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       in_valid,
	output logic       in_ready,
	input  req_item_t  in_item,
	output logic       out_valid,
	input  logic       out_ready,
	output cell_item_t out_item
);

	cell_stage_t       stg_q [CELL_W];
	logic [CELL_W-1:0] vld_q;
	logic [CELL_W-1:0] vin;
	logic [CELL_W:0]   rdy;
	cell_stage_t       head;

	assign rdy[CELL_W] = out_ready;
	assign vin         = {vld_q[CELL_W-2:0], in_valid};
	assign in_ready    = rdy[0];

	// a stage may load when the output is ready or any stage at or after it holds a bubble
	for (genvar g = 0; g < CELL_W; g++) begin : g_rdy
		assign rdy[g] = rdy[CELL_W] | ~(&vld_q[CELL_W-1:g]);
	end

	always_comb begin
		head     = '0;
		head.req = in_item.req;
		head.idx = in_item.idx;
		head.hgt = in_item.hgt;
		head.xlo = in_item.px[FRAC_W-1:0];
		head.zlo = in_item.pz[FRAC_W-1:0];
		head.xq  = in_item.px[POS_W-1:FRAC_W];
		head.zq  = in_item.pz[POS_W-1:FRAC_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int i = 0; i < CELL_W; i++) begin
				if (rdy[i]) begin
					vld_q[i] <= vin[i];
				end
			end
		end
	end

	for (genvar g = 0; g < CELL_W; g++) begin : g_stage
		cell_stage_t    src;
		cell_stage_t    nxt;
		logic [CFG_W:0] sx;
		logic [CFG_W:0] sz;

		if (g == 0) begin : g_src
			assign src = head;
		end else begin : g_src
			assign src = stg_q[g-1];
		end

		always_comb begin
			sx     = div_step(src.xr, src.xq[CELL_W-1], cfg.spacing);
			sz     = div_step(src.zr, src.zq[CELL_W-1], cfg.spacing);
			nxt    = src;
			nxt.xq = {src.xq[CELL_W-2:0], sx[CFG_W]};
			nxt.xr = sx[CFG_W-1:0];
			nxt.zq = {src.zq[CELL_W-2:0], sz[CFG_W]};
			nxt.zr = sz[CFG_W-1:0];
		end

		always_ff @(posedge clk) begin
			if (rdy[g] && vin[g]) begin
				stg_q[g] <= nxt;
			end
		end
	end

	assign out_valid    = vld_q[CELL_W-1];
	assign out_item.req = stg_q[CELL_W-1].req;
	assign out_item.idx = stg_q[CELL_W-1].idx;
	assign out_item.hgt = stg_q[CELL_W-1].hgt;
	assign out_item.col = stg_q[CELL_W-1].xq;
	assign out_item.row = stg_q[CELL_W-1].zq;
	assign out_item.fx  = {stg_q[CELL_W-1].xr, stg_q[CELL_W-1].xlo};
	assign out_item.fz  = {stg_q[CELL_W-1].zr, stg_q[CELL_W-1].zlo};

endmodule
`default_nettype wire

// ===== rtl/hth_seq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hth_seq: height memory sequencer
// Checks the cell against the grid, picks the triangle, then writes one
// height for a load or reads three corner heights for an on-grid query.
// ----------------------------------------------------------------------------
module hth_seq import hth_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  cfg_t         cfg,
	input  logic         in_valid,
	output logic         in_ready,
	input  cell_item_t   in_item,
	output logic         out_valid,
	input  logic         out_ready,
	output interp_item_t out_item
);

	prep_t             p_q;
	prep_t             p_nxt;
	logic              p_valid_q;
	logic              p_ready;

	seq_phase_t        phase_q;
	seq_phase_t        phase_nxt;

	logic              consume;
	logic              off_emit;
	logic              q_last;
	logic              ram_we;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_addr;
	logic [H_W-1:0]    ram_rdata;
	logic              o_free;

	logic              rd0_q;
	logic              rd1_q;
	logic              pend_q;
	logic [H_W-1:0]    h0_q;
	logic [H_W-1:0]    h1_q;
	logic              o_valid_q;
	interp_item_t      o_q;

	logic [FAR_W-1:0]  a00;
	logic [FAR_W-1:0]  far;
	logic [OFS_W-1:0]  cell_len;
	logic [OFS_W:0]    fsum;
	logic              upper;
	logic              off;

	// ---- prep: grid check, triangle select, corner addresses
	always_comb begin
		a00      = FAR_W'(in_item.row[CFG_W-1:0] * cfg.cols) +
		           FAR_W'(in_item.col[CFG_W-1:0]);
		far      = a00 + FAR_W'(cfg.cols) + FAR_W'(1);
		cell_len = {cfg.spacing, {FRAC_W{1'b0}}};
		fsum     = (OFS_W+1)'(in_item.fx) + (OFS_W+1)'(in_item.fz);
		upper    = fsum > (OFS_W+1)'(cell_len);
		off      = (cfg.cols < CFG_W'(2)) || (cfg.rows < CFG_W'(2)) ||
		           (in_item.col >= CELL_W'(cfg.cols) - CELL_W'(1)) ||
		           (in_item.row >= CELL_W'(cfg.rows) - CELL_W'(1)) ||
		           (32'(far) >= 32'(MAX_VERTICES));

		p_nxt     = '0;
		p_nxt.req = in_item.req;
		p_nxt.idx = in_item.idx;
		p_nxt.hgt = in_item.hgt;
		p_nxt.off = off;
		if (upper) begin
			p_nxt.a_base = ADDR_W'(a00 + FAR_W'(cfg.cols) + FAR_W'(1));
			p_nxt.a_a    = ADDR_W'(a00 + FAR_W'(cfg.cols));
			p_nxt.a_b    = ADDR_W'(a00 + FAR_W'(1));
			p_nxt.u      = cell_len - in_item.fx;
			p_nxt.v      = cell_len - in_item.fz;
		end else begin
			p_nxt.a_base = ADDR_W'(a00);
			p_nxt.a_a    = ADDR_W'(a00 + FAR_W'(1));
			p_nxt.a_b    = ADDR_W'(a00 + FAR_W'(cfg.cols));
			p_nxt.u      = in_item.fx;
			p_nxt.v      = in_item.fz;
		end
	end

	assign p_ready  = !p_valid_q || consume;
	assign in_ready = p_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_valid_q <= 1'b0;
		end else if (p_ready) begin
			p_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (p_ready && in_valid) begin
			p_q <= p_nxt;
		end
	end

	// ---- sequencer
	// o must be empty when the last corner read returns
	assign o_free = !o_valid_q || out_ready;

	always_comb begin
		phase_nxt = phase_q;
		if (p_valid_q && p_q.req == REQ_QUERY && !p_q.off) begin
			unique case (phase_q)
				PH_BASE:   phase_nxt = PH_SIDE_A;
				PH_SIDE_A: phase_nxt = PH_SIDE_B;
				PH_SIDE_B: begin
					if (o_free) begin
						phase_nxt = PH_BASE;
					end
				end
				default:   phase_nxt = PH_BASE;
			endcase
		end
	end

	always_comb begin
		consume  = 1'b0;
		off_emit = 1'b0;
		q_last   = 1'b0;
		ram_we   = 1'b0;
		ram_re   = 1'b0;
		ram_addr = p_q.a_base;
		if (p_valid_q) begin
			if (p_q.req == REQ_LOAD) begin
				ram_we   = 32'(p_q.idx) < 32'(MAX_VERTICES);
				ram_addr = ADDR_W'(p_q.idx);
				consume  = 1'b1;
			end else if (p_q.off) begin
				// no read in flight may land in o the same cycle
				if (o_free && !pend_q) begin
					off_emit = 1'b1;
					consume  = 1'b1;
				end
			end else begin
				unique case (phase_q)
					PH_BASE: begin
						ram_re   = 1'b1;
						ram_addr = p_q.a_base;
					end
					PH_SIDE_A: begin
						ram_re   = 1'b1;
						ram_addr = p_q.a_a;
					end
					PH_SIDE_B: begin
						if (o_free) begin
							ram_re   = 1'b1;
							ram_addr = p_q.a_b;
							q_last   = 1'b1;
							consume  = 1'b1;
						end
					end
					default: begin
						ram_re = 1'b0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_BASE;
			rd0_q     <= 1'b0;
			rd1_q     <= 1'b0;
			pend_q    <= 1'b0;
			o_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_nxt;
			rd0_q   <= ram_re && phase_q == PH_BASE;
			rd1_q   <= ram_re && phase_q == PH_SIDE_A;
			pend_q  <= q_last;
			if (pend_q || off_emit) begin
				o_valid_q <= 1'b1;
			end else if (out_ready) begin
				o_valid_q <= 1'b0;
			end
		end
	end

	hth_ram #(
		.WIDTH (H_W),
		.DEPTH (MAX_VERTICES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (p_q.hgt),
		.rdata (ram_rdata)
	);

	// ---- corner capture and output register
	always_ff @(posedge clk) begin
		if (rd0_q) begin
			h0_q <= ram_rdata;
		end
		if (rd1_q) begin
			h1_q <= ram_rdata;
		end
		if (q_last) begin
			o_q.off <= 1'b0;
			o_q.u   <= p_q.u;
			o_q.v   <= p_q.v;
		end
		if (off_emit) begin
			o_q.off <= 1'b1;
		end
		if (pend_q) begin
			o_q.base <= h0_q;
			o_q.ha   <= h1_q;
			o_q.hb   <= ram_rdata;
		end
	end

	assign out_valid = o_valid_q;
	assign out_item  = o_q;

endmodule
`default_nettype wire

// ===== rtl/hth_interp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hth_interp: triangle interpolation
// Height differences, two products, rounding offset, pipelined floor
// division by the spacing, base add and saturation.
// ----------------------------------------------------------------------------
module hth_interp import hth_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  interp_item_t          in_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic signed [H_W-1:0] height,
	output logic                  out_of_range
);

	logic [IP_STG-1:0]       v_q;
	logic [IP_STG-1:0]       vin;
	logic [IP_STG:0]         rdy;

	// s1: differences
	logic                    off_s1;
	logic signed [H_W-1:0]   base_s1;
	logic signed [H_W:0]     d1_s1;
	logic signed [H_W:0]     d2_s1;
	logic [OFS_W-1:0]        u_s1;
	logic [OFS_W-1:0]        v_s1;
	// s2: products
	logic                    off_s2;
	logic signed [H_W-1:0]   base_s2;
	logic signed [PROD_W-1:0] p1_s2;
	logic signed [PROD_W-1:0] p2_s2;
	logic signed [PROD_W-1:0] prod1;
	logic signed [PROD_W-1:0] prod2;
	// s3: rounded numerator, sign and magnitude
	logic                    off_s3;
	logic signed [H_W-1:0]   base_s3;
	logic                    neg_s3;
	logic [DIV_W-1:0]        mag_s3;
	logic [NUM_W-1:0]        num;
	logic [DIV_W:0]          shf;
	// divide stages
	div_stage_t              div_q [DIV_W];
	div_stage_t              div_head;
	// output
	logic signed [H_W-1:0]   height_q;
	logic                    oor_q;
	logic [DIV_W:0]          qs;
	logic [SUM_W-1:0]        y;
	logic signed [H_W-1:0]   y_sat;

	assign rdy[IP_STG] = out_ready;
	assign vin         = {v_q[IP_STG-2:0], in_valid};
	assign in_ready    = rdy[0];

	for (genvar g = 0; g < IP_STG; g++) begin : g_rdy
		assign rdy[g] = rdy[IP_STG] | ~(&v_q[IP_STG-1:g]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			for (int i = 0; i < IP_STG; i++) begin
				if (rdy[i]) begin
					v_q[i] <= vin[i];
				end
			end
		end
	end

	// ---- s1
	always_ff @(posedge clk) begin
		if (rdy[0] && vin[0]) begin
			off_s1  <= in_item.off;
			base_s1 <= in_item.base;
			d1_s1   <= {in_item.ha[H_W-1], in_item.ha} - {in_item.base[H_W-1], in_item.base};
			d2_s1   <= {in_item.hb[H_W-1], in_item.hb} - {in_item.base[H_W-1], in_item.base};
			u_s1    <= in_item.u;
			v_s1    <= in_item.v;
		end
	end

	// ---- s2
	assign prod1 = $signed({1'b0, u_s1}) * d1_s1;
	assign prod2 = $signed({1'b0, v_s1}) * d2_s1;

	always_ff @(posedge clk) begin
		if (rdy[1] && vin[1]) begin
			off_s2  <= off_s1;
			base_s2 <= base_s1;
			p1_s2   <= prod1;
			p2_s2   <= prod2;
		end
	end

	// ---- s3: n + L/2, then floor(/256) by shift; negative values are
	// complemented so floor division maps onto an unsigned divide
	always_comb begin
		num = {p1_s2[PROD_W-1], p1_s2} + {p2_s2[PROD_W-1], p2_s2} +
		      NUM_W'({cfg.spacing, {(FRAC_W-1){1'b0}}});
		shf = num[NUM_W-1:FRAC_W];
	end

	always_ff @(posedge clk) begin
		if (rdy[2] && vin[2]) begin
			off_s3  <= off_s2;
			base_s3 <= base_s2;
			neg_s3  <= num[NUM_W-1];
			mag_s3  <= num[NUM_W-1] ? ~shf[DIV_W-1:0] : shf[DIV_W-1:0];
		end
	end

	// ---- divide by spacing, one quotient bit per stage
	always_comb begin
		div_head      = '0;
		div_head.off  = off_s3;
		div_head.base = base_s3;
		div_head.neg  = neg_s3;
		div_head.dq   = mag_s3;
	end

	for (genvar g = 0; g < DIV_W; g++) begin : g_div
		div_stage_t     src;
		div_stage_t     nxt;
		logic [CFG_W:0] st;

		if (g == 0) begin : g_src
			assign src = div_head;
		end else begin : g_src
			assign src = div_q[g-1];
		end

		always_comb begin
			st      = div_step(src.rem, src.dq[DIV_W-1], cfg.spacing);
			nxt     = src;
			nxt.dq  = {src.dq[DIV_W-2:0], st[CFG_W]};
			nxt.rem = st[CFG_W-1:0];
		end

		always_ff @(posedge clk) begin
			if (rdy[g+3] && vin[g+3]) begin
				div_q[g] <= nxt;
			end
		end
	end

	// ---- output: undo complement, add base, saturate
	always_comb begin
		qs = div_q[DIV_W-1].neg ? ~{1'b0, div_q[DIV_W-1].dq} : {1'b0, div_q[DIV_W-1].dq};
		y  = {{(SUM_W-H_W){div_q[DIV_W-1].base[H_W-1]}}, div_q[DIV_W-1].base} +
		     {{(SUM_W-DIV_W-1){qs[DIV_W]}}, qs};
		if (!y[SUM_W-1] && (y[SUM_W-2:H_W-1] != '0)) begin
			y_sat = {1'b0, {(H_W-1){1'b1}}};
		end else if (y[SUM_W-1] && (y[SUM_W-2:H_W-1] != '1)) begin
			y_sat = {1'b1, {(H_W-1){1'b0}}};
		end else begin
			y_sat = y[H_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[IP_STG-1] && vin[IP_STG-1]) begin
			oor_q    <= div_q[DIV_W-1].off;
			height_q <= div_q[DIV_W-1].off ? '0 : y_sat;
		end
	end

	assign out_valid    = v_q[IP_STG-1];
	assign height       = height_q;
	assign out_of_range = oor_q;

endmodule
`default_nettype wire

// ===== rtl/heightmap_triangle_height.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// heightmap_triangle_height: terrain height lookup over a vertex grid
//
// s_axis takes one request per beat. tuser = 0 loads a vertex height
// (vertex_index, vertex_height) into the height memory and returns nothing;
// tuser = 1 queries the height at (pos_x, pos_z). m_axis returns one beat
// per query: tdata = interpolated height, tuser = out_of_range (height 0).
// cfg_* writes grid_columns (0), grid_rows (1), vertex_spacing (2); always
// ready, to be written only while the block is idle.
//
// Path: a query passes the 15-stage cell divider, the three height reads
// (none for a position off the grid) and the 34-stage interpolation divider.
// Throughput: the single-port height memory takes three reads per on-grid
// query, which holds the sequencer until its last read; loads 1 per cycle
// and off-grid queries 1 per cycle while the output register is free.
// Every pipeline stage loads into a bubble, so new beats keep entering while
// a result waits on m_axis_tready; with the pipe full, s_axis_tready drops.
// Reset clears all valid state and config to 128 x 128, spacing 1. Height
// memory content is not cleared; query only loaded vertices.
// ----------------------------------------------------------------------------
module heightmap_triangle_height import hth_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// slave stream
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_TDATA_W-1:0] s_axis_tdata,  // vertex_index, vertex_height, pos_x, pos_z
	input  logic                  s_axis_tuser,  // req_type
	// master stream
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [H_W-1:0]        m_axis_tdata,  // height
	output logic                  m_axis_tuser,  // out_of_range
	// config write
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [1:0]            cfg_index,
	input  logic [CFG_W-1:0]      cfg_data
);

	logic [CFG_W-1:0]      cols_q;
	logic [CFG_W-1:0]      rows_q;
	logic [CFG_W-1:0]      spacing_q;
	cfg_t                  cfg;

	req_item_t             req_item;
	logic                  cell_valid;
	logic                  cell_ready;
	cell_item_t            cell_item;
	logic                  ip_valid;
	logic                  ip_ready;
	interp_item_t          ip_item;
	logic signed [H_W-1:0] height;

	// ---- config registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q    <= CFG_W'(128);
			rows_q    <= CFG_W'(128);
			spacing_q <= CFG_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_COLS:    cols_q    <= cfg_data;
				CFG_ROWS:    rows_q    <= cfg_data;
				CFG_SPACING: spacing_q <= cfg_data;
				default:     cols_q    <= cols_q;
			endcase
		end
	end

	// zero spacing behaves as one
	assign cfg.cols    = cols_q;
	assign cfg.rows    = rows_q;
	assign cfg.spacing = (spacing_q == '0) ? CFG_W'(1) : spacing_q;

	// ---- request unpack, lowest field first
	assign req_item.req = s_axis_tuser;
	assign req_item.idx = s_axis_tdata[IDX_W-1:0];
	assign req_item.hgt = s_axis_tdata[IDX_W+H_W-1:IDX_W];
	assign req_item.px  = s_axis_tdata[IDX_W+H_W+POS_W-1:IDX_W+H_W];
	assign req_item.pz  = s_axis_tdata[IDX_W+H_W+2*POS_W-1:IDX_W+H_W+POS_W];

	// cell index and offsets
	hth_cell u_cell (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_item   (req_item),
		.out_valid (cell_valid),
		.out_ready (cell_ready),
		.out_item  (cell_item)
	);

	// grid check, height memory, corner fetch
	hth_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (cell_valid),
		.in_ready  (cell_ready),
		.in_item   (cell_item),
		.out_valid (ip_valid),
		.out_ready (ip_ready),
		.out_item  (ip_item)
	);

	// plane interpolation and output register
	hth_interp u_interp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (ip_valid),
		.in_ready     (ip_ready),
		.in_item      (ip_item),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.height       (height),
		.out_of_range (m_axis_tuser)
	);

	assign m_axis_tdata = height;

endmodule
`default_nettype wire
